// ===== hdl/assert_macros.svh =====
// assertion macros used by the rle decoder top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/isrle_pkg.sv =====
// types and codes for the image stream rle pixel decoder
package isrle_pkg;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_PULL  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        FMT_RAW565 = 2'd0,
        FMT_RAW332 = 2'd1,
        FMT_RLE565 = 2'd2,
        FMT_RLE332 = 2'd3
    } format_t;

    typedef enum logic [2:0] {
        ST_TAKEN   = 3'd0,
        ST_REFUSED = 3'd1,
        ST_PIXEL   = 3'd2,
        ST_NONE    = 3'd3,
        ST_ENDED   = 3'd4,
        ST_STARTED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CFG_PIXEL_FORMAT = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_index_t;

    localparam int unsigned CFG_DATA_W = 16;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] pixel_value;
        logic        final_pixel;
    } result_t;

    typedef struct packed {
        logic [1:0]  pixel_format;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } cfg_t;

endpackage

// ===== hdl/image_stream_rle_pixel_decoder_top.sv =====
// top level of the image stream rle pixel decoder
// Decodes image body bytes (raw or run-length, rgb565 or rgb332) into rgb565
// pixels. One word per clock is accepted and one result word is produced per
// accepted word; a result is offered once its word has passed the input
// register and then the result register, since the decode logic runs from the
// input register straight into the result register while the word sits in the
// input register. Words flow back to back as long as the result side takes one
// word per clock; while a result waits, the input register holds its word and
// item_ready drops. The start word loads the raw pixel count through a 16 by 16
// multiplier in that same decode cycle. Configuration writes are registered and
// are picked up by the next word decoded.
`include "assert_macros.svh"

module image_stream_rle_pixel_decoder_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  isrle_pkg::item_t                    item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output isrle_pkg::result_t                  result,
    input  logic                                cfg_write,
    input  logic [1:0]                          cfg_index,
    input  logic [isrle_pkg::CFG_DATA_W-1:0]    cfg_data
);

    isrle_pkg::item_t   item_reg;
    logic               item_valid_reg;
    isrle_pkg::result_t result_reg;
    logic               result_valid_reg;
    isrle_pkg::cfg_t    cfg_reg;
    isrle_pkg::result_t decoded;
    logic               proc_fire;

    // decode when the result register is free or being emptied
    assign proc_fire  = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || proc_fire;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_format <= isrle_pkg::FMT_RAW565;
            cfg_reg.image_width  <= 16'd1;
            cfg_reg.image_height <= 16'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                isrle_pkg::CFG_PIXEL_FORMAT: cfg_reg.pixel_format <= cfg_data[1:0];
                isrle_pkg::CFG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data;
                isrle_pkg::CFG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data;
                default:                     cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (proc_fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
        if (proc_fire)
        begin
            result_reg <= decoded;
        end
    end

    isrle_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (proc_fire),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (decoded)
    );

    `ASSERT_CLK(a_decode_fills_result, proc_fire |=> result_valid_reg,
        "decoded word did not reach the result register")
    `ASSERT_CLK(a_stalled_word_held, item_valid_reg && !proc_fire |=>
        item_valid_reg && $stable(item_reg), "waiting input word was lost or changed")
    `ASSERT_NEVER(a_final_only_on_pixel, result_valid_reg && result_reg.final_pixel &&
        result_reg.status != isrle_pkg::ST_PIXEL, "final pixel flag without a pixel")

endmodule

// ===== hdl/isrle_core.sv =====
// decode state and per-word decode logic of the rle pixel decoder
module isrle_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  isrle_pkg::item_t item,
    input  isrle_pkg::cfg_t  cfg,
    output isrle_pkg::result_t result
);

    logic [1:0]  record_phase_reg, record_phase_next;
    logic [7:0]  repeat_left_reg, repeat_left_next;
    logic [15:0] held_color_reg, held_color_next;
    logic [7:0]  pending_high_byte_reg, pending_high_byte_next;
    logic [31:0] raw_pixels_left_reg, raw_pixels_left_next;
    logic        image_over_reg, image_over_next;

    logic        owed;
    logic        raw_fmt;
    logic [31:0] pixel_total;

    // rgb332 to rgb565 by bit replication
    function automatic logic [15:0] widen332(input logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        begin
            hi = (b & 8'hE0) | ((b >> 2) & 8'h1F);
            lo = ((b << 3) & 8'hF8) | ((b << 2) & 8'h04) | (b & 8'h03);
            return {hi, lo};
        end
    endfunction

    assign owed        = (record_phase_reg == 2'd0) && (repeat_left_reg != 8'd0);
    assign raw_fmt     = !cfg.pixel_format[1];
    assign pixel_total = 32'(cfg.image_width) * 32'(cfg.image_height);

    always_comb
    begin
        record_phase_next      = record_phase_reg;
        repeat_left_next       = repeat_left_reg;
        held_color_next        = held_color_reg;
        pending_high_byte_next = pending_high_byte_reg;
        raw_pixels_left_next   = raw_pixels_left_reg;
        image_over_next        = image_over_reg;
        result.status          = isrle_pkg::ST_NONE;
        result.pixel_value     = 16'd0;
        result.final_pixel     = 1'b0;

        unique case (item.mode)
            isrle_pkg::MODE_START:
            begin
                raw_pixels_left_next   = pixel_total;
                record_phase_next      = 2'd0;
                repeat_left_next       = 8'd0;
                held_color_next        = 16'd0;
                pending_high_byte_next = 8'd0;
                image_over_next        = 1'b0;
                result.status          = isrle_pkg::ST_STARTED;
            end
            isrle_pkg::MODE_BYTE:
            begin
                if (image_over_reg)
                begin
                    result.status = isrle_pkg::ST_ENDED;
                end
                else if (owed)
                begin
                    result.status = isrle_pkg::ST_REFUSED;
                end
                else if (raw_fmt && raw_pixels_left_reg == 32'd0)
                begin
                    image_over_next = 1'b1;
                    result.status   = isrle_pkg::ST_ENDED;
                end
                else
                begin
                    result.status = isrle_pkg::ST_TAKEN;
                    unique case (cfg.pixel_format)
                        isrle_pkg::FMT_RAW565:
                        begin
                            if (record_phase_reg == 2'd0)
                            begin
                                pending_high_byte_next = item.data_byte;
                                record_phase_next      = 2'd1;
                            end
                            else
                            begin
                                held_color_next   = {pending_high_byte_reg, item.data_byte};
                                repeat_left_next  = 8'd1;
                                record_phase_next = 2'd0;
                            end
                        end
                        isrle_pkg::FMT_RAW332:
                        begin
                            held_color_next   = widen332(item.data_byte);
                            repeat_left_next  = 8'd1;
                            record_phase_next = 2'd0;
                        end
                        isrle_pkg::FMT_RLE565:
                        begin
                            if (record_phase_reg == 2'd0)
                            begin
                                // zero count is the end mark
                                if (item.data_byte == 8'd0)
                                begin
                                    image_over_next = 1'b1;
                                end
                                else
                                begin
                                    repeat_left_next  = item.data_byte;
                                    record_phase_next = 2'd1;
                                end
                            end
                            else if (record_phase_reg == 2'd1)
                            begin
                                pending_high_byte_next = item.data_byte;
                                record_phase_next      = 2'd2;
                            end
                            else
                            begin
                                held_color_next   = {pending_high_byte_reg, item.data_byte};
                                record_phase_next = 2'd0;
                            end
                        end
                        default:
                        begin
                            if (record_phase_reg == 2'd0)
                            begin
                                if (item.data_byte == 8'd0)
                                begin
                                    image_over_next = 1'b1;
                                end
                                else
                                begin
                                    repeat_left_next  = item.data_byte;
                                    record_phase_next = 2'd1;
                                end
                            end
                            else
                            begin
                                held_color_next   = widen332(item.data_byte);
                                record_phase_next = 2'd0;
                            end
                        end
                    endcase
                end
            end
            isrle_pkg::MODE_PULL:
            begin
                if (owed)
                begin
                    result.status      = isrle_pkg::ST_PIXEL;
                    result.pixel_value = held_color_reg;
                    repeat_left_next   = 8'(repeat_left_reg - 8'd1);
                    if (raw_fmt && raw_pixels_left_reg != 32'd0)
                    begin
                        raw_pixels_left_next = raw_pixels_left_reg - 32'd1;
                        if (raw_pixels_left_reg == 32'd1)
                        begin
                            result.final_pixel = 1'b1;
                            image_over_next    = 1'b1;
                        end
                    end
                end
                else if (image_over_reg)
                begin
                    result.status = isrle_pkg::ST_ENDED;
                end
            end
            default:
            begin
                result.status = isrle_pkg::ST_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_phase_reg      <= 2'd0;
            repeat_left_reg       <= 8'd0;
            held_color_reg        <= 16'd0;
            pending_high_byte_reg <= 8'd0;
            raw_pixels_left_reg   <= 32'd0;
            image_over_reg        <= 1'b1;
        end
        else if (fire)
        begin
            record_phase_reg      <= record_phase_next;
            repeat_left_reg       <= repeat_left_next;
            held_color_reg        <= held_color_next;
            pending_high_byte_reg <= pending_high_byte_next;
            raw_pixels_left_reg   <= raw_pixels_left_next;
            image_over_reg        <= image_over_next;
        end
    end

endmodule
